// ===== rtl/core/wst_pkg.sv =====
// ----------------------------------------------------------------------------
// wst_pkg
// Shared constants for the weight-of-evidence split table: field widths,
// fixed-point formats and row status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package wst_pkg;

    // Default sizing of the table.
    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_COUNT_BITS = 20;
    localparam int DEF_VALUE_BITS = 32;

    // Port field widths.
    localparam int SAMPLE_BITS    = 32;
    localparam int OUT_COUNT_BITS = 20;
    localparam int Q_BITS         = 24;
    localparam int STATUS_BITS    = 3;
    localparam int S_TDATA_BITS   = 40;
    localparam int M_TDATA_BITS   = 216;

    // Fixed-point formats.
    localparam int PCT_BITS       = 25;   // Q1.24 percentage, 1.0 included
    localparam int LOG_FRAC_BITS  = 24;   // log2 fraction bits
    localparam int MANT_BITS      = 31;   // Q1.30 normalized mantissa
    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    localparam logic signed [Q_BITS-1:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [Q_BITS-1:0] Q_MIN = -24'sh800000;

    // Row status codes.
    localparam logic [STATUS_BITS-1:0] ROW_STATUS_OK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] ROW_STATUS_CUM_UNDEF = 3'd1;
    localparam logic [STATUS_BITS-1:0] ROW_STATUS_REM_UNDEF = 3'd2;
    localparam logic [STATUS_BITS-1:0] ROW_STATUS_OVERFLOW  = 3'd4;

endpackage

`default_nettype wire

// ===== rtl/core/weight_of_evidence_split_table.sv =====
// ----------------------------------------------------------------------------
// weight_of_evidence_split_table
// Groups sorted labeled samples into rows of equal value and emits per row
// counts, cumulative and remaining weight of evidence and information value.
// ----------------------------------------------------------------------------
// Loading takes one sample word per cycle; each counted sample updates the
// row store. After the word marked tlast the table drains row by row, each
// row using the shared divider twice and the shared log2 unit six times.
// No sample is taken while the table drains.
// Synchronous active-low reset empties the table; row store contents are
// not cleared and are only read after being written.
`default_nettype none

module weight_of_evidence_split_table #(
    parameter int MAX_ROWS   = wst_pkg::DEF_MAX_ROWS,
    parameter int COUNT_BITS = wst_pkg::DEF_COUNT_BITS,
    parameter int VALUE_BITS = wst_pkg::DEF_VALUE_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // tdata: sample_value[31:0], label_is_one[32], zero pad
    input  wire logic [wst_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
    input  wire logic                              s_axis_tlast,
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // tdata: row_value[31:0], zero_count[51:32], ones_count[71:52],
    // total_count[91:72], woe_cumulative[115:92], iv_cumulative[139:116],
    // woe_remaining[163:140], iv_remaining[187:164], iv_total[211:188], pad
    output      logic [wst_pkg::M_TDATA_BITS-1:0]  m_axis_tdata,
    // tuser: row_status[2:0]
    output      logic [wst_pkg::STATUS_BITS-1:0]   m_axis_tuser,
    output      logic                              m_axis_tlast,
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready
);
    import wst_pkg::*;

    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int KW    = $clog2(COUNT_BITS);
    localparam int LW    = LOG_FRAC_BITS + KW;
    localparam int MW    = VALUE_BITS + 2 * COUNT_BITS;
    localparam int IPW   = PCT_BITS + Q_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    // Log operand selectors.
    localparam logic [2:0] LOG_CO = 3'd0;
    localparam logic [2:0] LOG_Z  = 3'd1;
    localparam logic [2:0] LOG_CZ = 3'd2;
    localparam logic [2:0] LOG_O  = 3'd3;
    localparam logic [2:0] LOG_RO = 3'd4;
    localparam logic [2:0] LOG_RZ = 3'd5;
    localparam int         NLOG   = 6;

    typedef enum logic [9:0] {
        ST_LOAD  = 10'b0000000001,
        ST_READ  = 10'b0000000010,
        ST_FETCH = 10'b0000000100,
        ST_DIV   = 10'b0000001000,
        ST_LOG   = 10'b0000010000,
        ST_WMUL  = 10'b0000100000,
        ST_WRND  = 10'b0001000000,
        ST_IMUL  = 10'b0010000000,
        ST_IRND  = 10'b0100000000,
        ST_EMIT  = 10'b1000000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [RCW-1:0]           rows_reg, rows_next;
    logic                     first_reg, first_next;
    logic                     ovf_reg, ovf_next;
    logic [COUNT_BITS-1:0]    gz_reg, gz_next, go_reg, go_next;
    logic [VALUE_BITS-1:0]    cur_val_reg, cur_val_next;
    logic [COUNT_BITS-1:0]    cur_zc_reg, cur_zc_next, cur_oc_reg, cur_oc_next;
    logic [RIW-1:0]           row_idx_reg, row_idx_next;
    logic [COUNT_BITS-1:0]    cz_reg, cz_next, co_reg, co_next;
    logic [VALUE_BITS-1:0]    val_reg, val_next;
    logic [COUNT_BITS-1:0]    zc_reg, zc_next, oc_reg, oc_next;
    logic                     div_start_reg, div_start_next;
    logic                     dsel_reg, dsel_next;
    logic [PCT_BITS-1:0]      pct_co_reg, pct_co_next, pct_cz_reg, pct_cz_next;
    logic                     log_start_reg, log_start_next;
    logic [2:0]               lsel_reg, lsel_next;
    logic [LW-1:0]            log_res_reg [NLOG];
    logic [LW-1:0]            log_res_next [NLOG];
    logic                     wsel_reg, wsel_next;
    logic                     wneg_reg, wneg_next;
    logic [63:0]              wprod_reg, wprod_next;
    logic signed [Q_BITS-1:0] woe_c_reg, woe_c_next, woe_r_reg, woe_r_next;
    logic [IPW-1:0]           iprod_reg, iprod_next;
    logic                     ineg_reg, ineg_next;
    logic signed [Q_BITS+1:0] ic_reg, ic_next, ir_reg, ir_next;
    logic                     m_valid_reg, m_valid_next;
    logic [M_TDATA_BITS-1:0]  m_data_reg, m_data_next;
    logic [STATUS_BITS-1:0]   m_user_reg, m_user_next;
    logic                     m_last_reg, m_last_next;

    // Load path.
    logic                     in_fire, label, is_new, do_open, ovf_in, cnt_act;
    logic [63:0]              samp_sx;
    logic [VALUE_BITS-1:0]    samp_val;
    logic [RCW-1:0]           rows_m1;
    logic [COUNT_BITS-1:0]    zc_base, oc_base, zc_new, oc_new;
    logic                     mem_wr_en;
    logic [RIW-1:0]           mem_wr_addr;
    logic [MW-1:0]            mem_rd_data;

    // Drain path.
    logic [COUNT_BITS-1:0]    rd_zc, rd_oc, rz, ro;
    logic [VALUE_BITS-1:0]    rd_val;
    logic [COUNT_BITS:0]      cz_sum, co_sum, tc_sum;
    logic [COUNT_BITS-1:0]    tc;
    logic                     div_done, log_done;
    logic [PCT_BITS-1:0]      div_quot;
    logic [LW-1:0]            log_result;
    logic [COUNT_BITS-1:0]    div_num, div_den, log_n;
    logic signed [LW+1:0]     l_cum, l_rem, l_sel, l_mag;
    logic [63:0]              wr_round;
    logic signed [Q_BITS-1:0] woe_val, w_sel;
    logic signed [PCT_BITS:0] d_diff;
    logic [PCT_BITS-1:0]      d_mag;
    logic                     d_neg;
    logic [Q_BITS-1:0]        w_mag;
    logic [IPW-1:0]           iv_round;
    logic signed [Q_BITS+1:0] iv_val;
    logic                     und_c, und_r, emit_last, emit_load;
    logic signed [Q_BITS+2:0] it_sum;
    logic signed [Q_BITS-1:0] wc_o, wr_o, ic_o, ir_o, it_o;
    logic [63:0]              val64, zc64, oc64, tc64;

    // ------------------------------------------------------------------
    // Load path
    // ------------------------------------------------------------------
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign label    = s_axis_tdata[SAMPLE_BITS];
    assign samp_sx  = {{(64-SAMPLE_BITS){s_axis_tdata[SAMPLE_BITS-1]}},
                       s_axis_tdata[SAMPLE_BITS-1:0]};
    assign samp_val = samp_sx[VALUE_BITS-1:0];
    assign rows_m1  = rows_reg - RCW'(1);

    assign is_new   = !ovf_reg && (first_reg || samp_val != cur_val_reg);
    assign do_open  = is_new && (rows_reg < RCW'(MAX_ROWS));
    assign ovf_in   = ovf_reg || (is_new && !do_open);
    assign cnt_act  = !ovf_in;

    assign zc_base  = do_open ? '0 : cur_zc_reg;
    assign oc_base  = do_open ? '0 : cur_oc_reg;
    assign zc_new   = (cnt_act && !label && zc_base != CMAX) ? zc_base + 1'b1 : zc_base;
    assign oc_new   = (cnt_act && label && oc_base != CMAX) ? oc_base + 1'b1 : oc_base;

    // Every counted sample rewrites its row, so the store is complete at tlast.
    assign mem_wr_en   = in_fire && cnt_act;
    assign mem_wr_addr = do_open ? rows_reg[RIW-1:0] : rows_m1[RIW-1:0];

    wst_row_mem #(
        .MAX_ROWS (MAX_ROWS),
        .WIDTH    (MW),
        .ADDR_W   (RIW)
    ) u_row_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data ({do_open ? samp_val : cur_val_reg, zc_new, oc_new}),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (row_idx_reg),
        .rd_data (mem_rd_data)
    );

    // ------------------------------------------------------------------
    // Drain path
    // ------------------------------------------------------------------
    assign rd_val = mem_rd_data[MW-1:2*COUNT_BITS];
    assign rd_zc  = mem_rd_data[2*COUNT_BITS-1:COUNT_BITS];
    assign rd_oc  = mem_rd_data[COUNT_BITS-1:0];
    assign cz_sum = {1'b0, cz_reg} + {1'b0, rd_zc};
    assign co_sum = {1'b0, co_reg} + {1'b0, rd_oc};
    assign rz     = gz_reg - cz_reg;
    assign ro     = go_reg - co_reg;

    assign div_num = dsel_reg ? cz_reg : co_reg;
    assign div_den = dsel_reg ? gz_reg : go_reg;

    wst_pct_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_pct_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb begin
        case (lsel_reg)
            LOG_CO:  log_n = co_reg;
            LOG_Z:   log_n = gz_reg;
            LOG_CZ:  log_n = cz_reg;
            LOG_O:   log_n = go_reg;
            LOG_RO:  log_n = ro;
            LOG_RZ:  log_n = rz;
            default: log_n = '0;
        endcase
    end

    wst_log2 #(
        .COUNT_BITS (COUNT_BITS),
        .LOG_W      (LW)
    ) u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (log_start_reg),
        .n       (log_n),
        .done    (log_done),
        .result  (log_result)
    );

    assign l_cum = $signed({2'b00, log_res_reg[LOG_CO]}) + $signed({2'b00, log_res_reg[LOG_Z]})
                 - $signed({2'b00, log_res_reg[LOG_CZ]}) - $signed({2'b00, log_res_reg[LOG_O]});
    assign l_rem = $signed({2'b00, log_res_reg[LOG_RO]}) + $signed({2'b00, log_res_reg[LOG_Z]})
                 - $signed({2'b00, log_res_reg[LOG_RZ]}) - $signed({2'b00, log_res_reg[LOG_O]});
    assign l_sel = wsel_reg ? l_rem : l_cum;
    assign l_mag = l_sel[LW+1] ? -l_sel : l_sel;

    // Scale by ln 2 and round half away from zero to Q8.16, then saturate.
    assign wr_round = (wprod_reg + (64'd1 << 39)) >> 40;
    always_comb begin
        if (wneg_reg) begin
            woe_val = (wr_round > 64'd8388608) ? Q_MIN : -$signed(wr_round[Q_BITS-1:0]);
        end else begin
            woe_val = (wr_round > 64'd8388607) ? Q_MAX : $signed(wr_round[Q_BITS-1:0]);
        end
    end

    assign d_diff = $signed({1'b0, pct_co_reg}) - $signed({1'b0, pct_cz_reg});
    assign d_mag  = d_diff[PCT_BITS] ? PCT_BITS'(-d_diff) : d_diff[PCT_BITS-1:0];
    // The remaining side uses the negated difference.
    assign d_neg  = wsel_reg ? (!d_diff[PCT_BITS] && d_diff != '0) : d_diff[PCT_BITS];
    assign w_sel  = wsel_reg ? woe_r_reg : woe_c_reg;
    assign w_mag  = w_sel[Q_BITS-1] ? Q_BITS'(-w_sel) : w_sel;

    assign iv_round = (iprod_reg + (IPW'(1) << 23)) >> 24;
    assign iv_val   = ineg_reg ? -$signed(iv_round[Q_BITS+1:0]) : $signed(iv_round[Q_BITS+1:0]);

    // Output assembly.
    assign und_c     = (cz_reg == '0) || (co_reg == '0);
    assign und_r     = (rz == '0) || (ro == '0);
    assign tc_sum    = {1'b0, zc_reg} + {1'b0, oc_reg};
    assign tc        = tc_sum[COUNT_BITS] ? CMAX : tc_sum[COUNT_BITS-1:0];
    assign it_sum    = (Q_BITS+3)'(ic_reg) + (Q_BITS+3)'(ir_reg);
    assign emit_last = ({{(RCW-RIW){1'b0}}, row_idx_reg} == rows_m1);
    assign emit_load = !m_valid_reg || m_axis_tready;

    always_comb begin
        wc_o = und_c ? '0 : woe_c_reg;
        ic_o = und_c ? '0 : ic_reg[Q_BITS-1:0];
        wr_o = und_r ? '0 : woe_r_reg;
        ir_o = und_r ? '0 : ir_reg[Q_BITS-1:0];
        if (und_c || und_r) begin
            it_o = '0;
        end else if (it_sum > (Q_BITS+3)'(Q_MAX)) begin
            it_o = Q_MAX;
        end else if (it_sum < (Q_BITS+3)'(Q_MIN)) begin
            it_o = Q_MIN;
        end else begin
            it_o = it_sum[Q_BITS-1:0];
        end
    end

    assign val64 = 64'(val_reg);
    assign zc64  = 64'(zc_reg);
    assign oc64  = 64'(oc_reg);
    assign tc64  = 64'(tc);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        rows_next      = rows_reg;
        first_next     = first_reg;
        ovf_next       = ovf_reg;
        gz_next        = gz_reg;
        go_next        = go_reg;
        cur_val_next   = cur_val_reg;
        cur_zc_next    = cur_zc_reg;
        cur_oc_next    = cur_oc_reg;
        row_idx_next   = row_idx_reg;
        cz_next        = cz_reg;
        co_next        = co_reg;
        val_next       = val_reg;
        zc_next        = zc_reg;
        oc_next        = oc_reg;
        div_start_next = 1'b0;
        dsel_next      = dsel_reg;
        pct_co_next    = pct_co_reg;
        pct_cz_next    = pct_cz_reg;
        log_start_next = 1'b0;
        lsel_next      = lsel_reg;
        log_res_next   = log_res_reg;
        wsel_next      = wsel_reg;
        wneg_next      = wneg_reg;
        wprod_next     = wprod_reg;
        woe_c_next     = woe_c_reg;
        woe_r_next     = woe_r_reg;
        iprod_next     = iprod_reg;
        ineg_next      = ineg_reg;
        ic_next        = ic_reg;
        ir_next        = ir_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_last_next    = m_last_reg;

        case (state_reg)
            ST_LOAD: begin
                if (in_fire) begin
                    if (is_new) begin
                        first_next = 1'b0;
                    end
                    if (do_open) begin
                        rows_next    = rows_reg + RCW'(1);
                        cur_val_next = samp_val;
                    end
                    ovf_next    = ovf_in;
                    cur_zc_next = zc_new;
                    cur_oc_next = oc_new;
                    if (!label && gz_reg != CMAX) begin
                        gz_next = gz_reg + 1'b1;
                    end
                    if (label && go_reg != CMAX) begin
                        go_next = go_reg + 1'b1;
                    end
                    if (s_axis_tlast) begin
                        row_idx_next = '0;
                        cz_next      = '0;
                        co_next      = '0;
                        state_next   = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                val_next       = rd_val;
                zc_next        = rd_zc;
                oc_next        = rd_oc;
                cz_next        = (cz_sum > {1'b0, gz_reg}) ? gz_reg : cz_sum[COUNT_BITS-1:0];
                co_next        = (co_sum > {1'b0, go_reg}) ? go_reg : co_sum[COUNT_BITS-1:0];
                dsel_next      = 1'b0;
                div_start_next = 1'b1;
                state_next     = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    if (!dsel_reg) begin
                        pct_co_next    = div_quot;
                        dsel_next      = 1'b1;
                        div_start_next = 1'b1;
                    end else begin
                        pct_cz_next    = div_quot;
                        lsel_next      = LOG_CO;
                        log_start_next = 1'b1;
                        state_next     = ST_LOG;
                    end
                end
            end
            ST_LOG: begin
                if (log_done) begin
                    log_res_next[lsel_reg] = log_result;
                    if (lsel_reg == LOG_RZ) begin
                        wsel_next  = 1'b0;
                        state_next = ST_WMUL;
                    end else begin
                        lsel_next      = lsel_reg + 3'd1;
                        log_start_next = 1'b1;
                    end
                end
            end
            ST_WMUL: begin
                wneg_next  = l_sel[LW+1];
                wprod_next = l_mag[LW:0] * LN2_Q32;
                state_next = ST_WRND;
            end
            ST_WRND: begin
                if (!wsel_reg) begin
                    woe_c_next = woe_val;
                    wsel_next  = 1'b1;
                    state_next = ST_WMUL;
                end else begin
                    woe_r_next = woe_val;
                    wsel_next  = 1'b0;
                    state_next = ST_IMUL;
                end
            end
            ST_IMUL: begin
                ineg_next  = d_neg ^ w_sel[Q_BITS-1];
                iprod_next = d_mag * w_mag;
                state_next = ST_IRND;
            end
            ST_IRND: begin
                if (!wsel_reg) begin
                    ic_next    = iv_val;
                    wsel_next  = 1'b1;
                    state_next = ST_IMUL;
                end else begin
                    ir_next    = iv_val;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_load) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0000, it_o, ir_o, wr_o, ic_o, wc_o,
                                    tc64[OUT_COUNT_BITS-1:0], oc64[OUT_COUNT_BITS-1:0],
                                    zc64[OUT_COUNT_BITS-1:0], val64[SAMPLE_BITS-1:0]};
                    m_last_next  = emit_last;
                    if (ovf_reg && emit_last) begin
                        m_user_next = ROW_STATUS_OVERFLOW;
                    end else begin
                        m_user_next = ROW_STATUS_OK
                                    | (und_c ? ROW_STATUS_CUM_UNDEF : ROW_STATUS_OK)
                                    | (und_r ? ROW_STATUS_REM_UNDEF : ROW_STATUS_OK);
                    end
                    if (emit_last) begin
                        // Table done: back to an empty table.
                        rows_next  = '0;
                        first_next = 1'b1;
                        ovf_next   = 1'b0;
                        gz_next    = '0;
                        go_next    = '0;
                        cz_next    = '0;
                        co_next    = '0;
                        state_next = ST_LOAD;
                    end else begin
                        row_idx_next = row_idx_reg + RIW'(1);
                        state_next   = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            rows_reg      <= '0;
            first_reg     <= 1'b1;
            ovf_reg       <= 1'b0;
            gz_reg        <= '0;
            go_reg        <= '0;
            cz_reg        <= '0;
            co_reg        <= '0;
            row_idx_reg   <= '0;
            div_start_reg <= 1'b0;
            log_start_reg <= 1'b0;
            dsel_reg      <= 1'b0;
            lsel_reg      <= LOG_CO;
            wsel_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            first_reg     <= first_next;
            ovf_reg       <= ovf_next;
            gz_reg        <= gz_next;
            go_reg        <= go_next;
            cz_reg        <= cz_next;
            co_reg        <= co_next;
            row_idx_reg   <= row_idx_next;
            div_start_reg <= div_start_next;
            log_start_reg <= log_start_next;
            dsel_reg      <= dsel_next;
            lsel_reg      <= lsel_next;
            wsel_reg      <= wsel_next;
            m_valid_reg   <= m_valid_next;
        end
        cur_val_reg <= cur_val_next;
        cur_zc_reg  <= cur_zc_next;
        cur_oc_reg  <= cur_oc_next;
        val_reg     <= val_next;
        zc_reg      <= zc_next;
        oc_reg      <= oc_next;
        pct_co_reg  <= pct_co_next;
        pct_cz_reg  <= pct_cz_next;
        log_res_reg <= log_res_next;
        wneg_reg    <= wneg_next;
        wprod_reg   <= wprod_next;
        woe_c_reg   <= woe_c_next;
        woe_r_reg   <= woe_r_next;
        iprod_reg   <= iprod_next;
        ineg_reg    <= ineg_next;
        ic_reg      <= ic_next;
        ir_reg      <= ir_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
        m_last_reg  <= m_last_next;
    end

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    ap_rows_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rows_reg <= RCW'(MAX_ROWS))
        else $error("row count exceeds table capacity");

    ap_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> rows_reg == RCW'(MAX_ROWS))
        else $error("overflow flagged before table is full");

    ap_cum_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (cz_reg <= gz_reg) && (co_reg <= go_reg))
        else $error("cumulative count above grand total");

    ap_drain_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_axis_tlast) |=> (state_reg == ST_READ && rows_reg != '0))
        else $error("drain did not start with a non-empty table");

    ap_drain_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && emit_load && emit_last)
        |=> (state_reg == ST_LOAD && rows_reg == '0 && first_reg))
        else $error("table not emptied after last row");

endmodule

`default_nettype wire

// ===== rtl/core/wst_row_mem.sv =====
// ----------------------------------------------------------------------------
// wst_row_mem
// Row store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wst_row_mem #(
    parameter int MAX_ROWS = 64,
    parameter int WIDTH    = 72,
    parameter int ADDR_W   = 6
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [MAX_ROWS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/wst_pct_div.sv =====
// ----------------------------------------------------------------------------
// wst_pct_div
// Restoring divider for floor(num * 2^24 / den), one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wst_pct_div #(
    parameter int COUNT_BITS = 20
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [COUNT_BITS-1:0]           num,
    input  wire logic [COUNT_BITS-1:0]           den,
    output      logic                            done,
    output      logic [wst_pkg::PCT_BITS-1:0]    quot
);
    import wst_pkg::*;

    localparam int STEP_W = $clog2(PCT_BITS);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [COUNT_BITS:0]   rem_reg, rem_next;
    logic [COUNT_BITS-1:0] den_reg, den_next;
    logic [PCT_BITS-1:0]   q_reg, q_next;
    logic [COUNT_BITS:0]   trial;
    logic                  ge;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        // The first step tests the integer bit, so the remainder is not doubled.
        trial = (step_reg == '0) ? rem_reg : {rem_reg[COUNT_BITS-1:0], 1'b0};
        ge    = trial >= {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = {1'b0, num};
            den_next  = den;
            q_next    = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? trial - {1'b0, den_reg} : trial;
            q_next    = {q_reg[PCT_BITS-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(PCT_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    // An empty total gives a zero percentage.
    assign quot = (den_reg == '0) ? '0 : q_reg;

endmodule

`default_nettype wire

// ===== rtl/core/wst_log2.sv =====
// ----------------------------------------------------------------------------
// wst_log2
// Iterative log2 of a count in Q.24: leading-one search, then one squaring
// of the Q1.30 mantissa per cycle, each giving one fraction bit.
// ----------------------------------------------------------------------------
`default_nettype none

module wst_log2 #(
    parameter int COUNT_BITS = 20,
    parameter int LOG_W      = 29
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [COUNT_BITS-1:0] n,
    output      logic                  done,
    output      logic [LOG_W-1:0]      result
);
    import wst_pkg::*;

    localparam int KW     = LOG_W - LOG_FRAC_BITS;
    localparam int STEP_W = $clog2(LOG_FRAC_BITS);
    localparam int WIDE_W = COUNT_BITS + MANT_BITS - 1;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [KW-1:0]            k_reg, k_next;
    logic [MANT_BITS-1:0]     m_reg, m_next;
    logic [LOG_FRAC_BITS-1:0] frac_reg, frac_next;
    logic [KW-1:0]            k_in;
    logic [WIDE_W-1:0]        wide;
    logic [2*MANT_BITS-1:0]   sq;
    logic [MANT_BITS:0]       sq_top;

    always_comb begin
        k_in = '0;
        for (int i = 0; i < COUNT_BITS; i++) begin
            if (n[i]) begin
                k_in = KW'(i);
            end
        end
    end

    assign wide   = {n, {(MANT_BITS-1){1'b0}}} >> k_in;
    assign sq     = m_reg * m_reg;
    assign sq_top = sq[2*MANT_BITS-1:MANT_BITS-1];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        k_next    = k_reg;
        m_next    = m_reg;
        frac_next = frac_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            k_next    = k_in;
            m_next    = wide[MANT_BITS-1:0];
            frac_next = '0;
        end else if (busy_reg) begin
            // A square of two or more yields a one bit and is halved.
            frac_next = {frac_reg[LOG_FRAC_BITS-2:0], sq_top[MANT_BITS]};
            m_next    = sq_top[MANT_BITS] ? sq_top[MANT_BITS:1] : sq_top[MANT_BITS-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(LOG_FRAC_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        k_reg    <= k_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
    end

    assign done   = done_reg;
    assign result = {k_reg, frac_reg};

endmodule

`default_nettype wire
